>>> rtl/apu_dmc_frame_irq_timing_top_defines.svh
// Assertion macros for the DMC and frame counter timing block.
// Used by the back-end module; no other dependencies.
`ifndef APU_DMC_FRAME_IRQ_TIMING_TOP_DEFINES_SVH
`define APU_DMC_FRAME_IRQ_TIMING_TOP_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define ADFIT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adfit implication check failed");

// Next-cycle implication, checked while out of reset.
`define ADFIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adfit next-cycle check failed");

`endif

>>> rtl/adfit_pkg.sv
// Shared types, codes and tables for the DMC and frame counter timing block.
// No dependencies.
package adfit_pkg;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_SRESET = 2'd3;

  localparam logic [2:0] REG_RATE  = 3'd0;
  localparam logic [2:0] REG_ADDR  = 3'd2;
  localparam logic [2:0] REG_LEN   = 3'd3;
  localparam logic [2:0] REG_CTRL  = 3'd5;
  localparam logic [2:0] REG_FRAME = 3'd7;

  localparam logic [19:0] FRAME_PERIOD_RESET = 20'd357960;
  localparam logic [21:0] FRAME_ACC_MIN      = 22'h200000;
  localparam logic [8:0]  SMP_PERIOD_RESET   = 9'd428;
  localparam logic [2:0]  FETCH_STALL        = 3'd4;

  typedef enum logic [3:0] {
    OP_TICK,
    OP_WR_RATE,
    OP_WR_ADDR,
    OP_WR_LEN,
    OP_WR_CTRL,
    OP_WR_FRAME,
    OP_READ,
    OP_SRESET,
    OP_NOP
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [5:0] cycles;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic {
    BK_RUN,
    BK_TICK2
  } bk_state_e;

  function automatic logic [8:0] rate_period(input logic [3:0] idx);
    logic [8:0] p;
    case (idx)
      4'd0:    p = 9'd428;
      4'd1:    p = 9'd380;
      4'd2:    p = 9'd340;
      4'd3:    p = 9'd320;
      4'd4:    p = 9'd286;
      4'd5:    p = 9'd254;
      4'd6:    p = 9'd226;
      4'd7:    p = 9'd214;
      4'd8:    p = 9'd190;
      4'd9:    p = 9'd160;
      4'd10:   p = 9'd142;
      4'd11:   p = 9'd128;
      4'd12:   p = 9'd106;
      4'd13:   p = 9'd84;
      4'd14:   p = 9'd72;
      default: p = 9'd54;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/adfit_front.sv
// Front end: accepts input items and classifies them into commands.
// Depends on adfit_pkg; feeds adfit_queue.
module adfit_front import adfit_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [5:0] cycles_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  cmd_op_e op;

  always_comb begin
    op = OP_NOP;
    case (mode_i)
      MODE_TICK:   op = OP_TICK;
      MODE_READ:   op = OP_READ;
      MODE_SRESET: op = OP_SRESET;
      MODE_WRITE: begin
        case (reg_index_i)
          REG_RATE:  op = OP_WR_RATE;
          REG_ADDR:  op = OP_WR_ADDR;
          REG_LEN:   op = OP_WR_LEN;
          REG_CTRL:  op = OP_WR_CTRL;
          REG_FRAME: op = OP_WR_FRAME;
          default:   op = OP_NOP;
        endcase
      end
      default:     op = OP_NOP;
    endcase
  end

  assign cmd_o      = '{op: op, cycles: cycles_i, data: write_data_i};
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

endmodule

>>> rtl/adfit_queue.sv
// Two-entry command queue between front and back end.
// Depends on adfit_pkg.
module adfit_queue import adfit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign do_pop       = pop_i & (count_q != 2'd0);
  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/adfit_back.sv
// Back end: frame counter, sample DMA and interrupt state, plus output register.
// Depends on adfit_pkg and the assertion macro header.
`include "apu_dmc_frame_irq_timing_top_defines.svh"
module adfit_back import adfit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [19:0] cfg_data_i,
  input  logic        head_valid_i,
  input  cmd_t        head_cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        irq_raise_o,
  output logic        irq_clear_o,
  output logic        dma_fetch_o,
  output logic [15:0] dma_address_o,
  output logic [2:0]  stall_cycles_o
);

  bk_state_e state_q, state_d;

  logic [19:0]        frame_period_q, frame_period_d;
  logic signed [21:0] frame_acc_q, frame_acc_d;
  logic [1:0]         frame_step_q, frame_step_d;
  logic [1:0]         frame_mode_q, frame_mode_d;
  logic [1:0]         irq_q, irq_d;
  logic signed [9:0]  smp_acc_q, smp_acc_d;
  logic [8:0]         smp_period_q, smp_period_d;
  logic [14:0]        smp_addr_q, smp_addr_d;
  logic [11:0]        bytes_q, bytes_d;
  logic [7:0]         fmt_q, fmt_d;
  logic [7:0]         addr_latch_q, addr_latch_d;
  logic [7:0]         len_latch_q, len_latch_d;
  logic [2:0]         bit_cnt_q, bit_cnt_d;
  logic               fetch_done_q, fetch_done_d;

  logic [5:0]  tick_cycles_q, tick_cycles_d;
  logic        tick_raise_q, tick_raise_d;
  logic        tick_fetch_q, tick_fetch_d;
  logic [15:0] tick_addr_q, tick_addr_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_rd_q, out_rd_d;
  logic        out_raise_q, out_raise_d;
  logic        out_clr_q, out_clr_d;
  logic        out_fetch_q, out_fetch_d;
  logic [15:0] out_addr_q, out_addr_d;
  logic [2:0]  out_stall_q, out_stall_d;

  logic        out_free;
  logic [11:0] c48;
  logic [22:0] frame_diff;
  logic [21:0] frame_sub;
  logic        frame_le0;
  logic        frame_extra;
  logic [21:0] reload_amt;
  logic [11:0] bytes_dec;
  logic [14:0] load_addr;
  logic [11:0] load_len;
  logic signed [9:0] s0, s1, s2;
  logic        n1, n2;
  logic [2:0]  bc1, bc2;

  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign load_addr = {1'b1, addr_latch_q, 6'b0};
  assign load_len  = {len_latch_q, 4'b0001};
  assign c48        = {1'b0, head_cmd_i.cycles, 5'b0} + {2'b0, head_cmd_i.cycles, 4'b0};
  assign frame_diff = {frame_acc_q[21], frame_acc_q} - {11'b0, c48};
  assign frame_sub  = (frame_diff[22:21] == 2'b10) ? FRAME_ACC_MIN : frame_diff[21:0];
  assign bytes_dec  = bytes_q - 12'd1;

  assign frame_le0   = frame_acc_q[21] | (frame_acc_q == '0);
  assign frame_extra = (frame_step_q == 2'd3) & frame_mode_q[1];
  assign reload_amt  = frame_extra ? {1'b0, frame_period_q, 1'b0} : {2'b0, frame_period_q};

  assign s0  = smp_acc_q - $signed({4'b0, tick_cycles_q});
  assign n1  = s0[9] | (s0 == '0);
  assign s1  = n1 ? s0 + $signed({1'b0, smp_period_q}) : s0;
  assign n2  = n1 & (s1[9] | (s1 == '0));
  assign s2  = n2 ? s1 + $signed({1'b0, smp_period_q}) : s1;
  assign bc1 = bit_cnt_q + 3'(n1);
  assign bc2 = bc1 + 3'(n2);

  always_comb begin
    state_d        = state_q;
    frame_period_d = cfg_valid_i ? cfg_data_i : frame_period_q;
    frame_acc_d    = frame_acc_q;
    frame_step_d   = frame_step_q;
    frame_mode_d   = frame_mode_q;
    irq_d          = irq_q;
    smp_acc_d      = smp_acc_q;
    smp_period_d   = smp_period_q;
    smp_addr_d     = smp_addr_q;
    bytes_d        = bytes_q;
    fmt_d          = fmt_q;
    addr_latch_d   = addr_latch_q;
    len_latch_d    = len_latch_q;
    bit_cnt_d      = bit_cnt_q;
    fetch_done_d   = fetch_done_q;
    tick_cycles_d  = tick_cycles_q;
    tick_raise_d   = tick_raise_q;
    tick_fetch_d   = tick_fetch_q;
    tick_addr_d    = tick_addr_q;
    pop_o          = 1'b0;
    out_valid_d    = out_valid_q & out_stall_i;
    out_rd_d       = out_rd_q;
    out_raise_d    = out_raise_q;
    out_clr_d      = out_clr_q;
    out_fetch_d    = out_fetch_q;
    out_addr_d     = out_addr_q;
    out_stall_d    = out_stall_q;

    case (state_q)
      BK_RUN: begin
        if (head_valid_i && head_cmd_i.op == OP_TICK) begin
          pop_o         = 1'b1;
          state_d       = BK_TICK2;
          tick_cycles_d = head_cmd_i.cycles;
          frame_acc_d   = frame_sub;
          tick_raise_d  = 1'b0;
          tick_fetch_d  = 1'b0;
          tick_addr_d   = '0;
          if (bytes_q != '0 && !fetch_done_q) begin
            tick_fetch_d = 1'b1;
            tick_addr_d  = {1'b1, smp_addr_q};
            fetch_done_d = 1'b1;
            smp_addr_d   = smp_addr_q + 15'd1;
            bytes_d      = bytes_dec;
            if (bytes_dec == '0) begin
              if (fmt_q[6]) begin
                smp_addr_d = load_addr;
                bytes_d    = load_len;
              end else if (fmt_q[7]) begin
                irq_d[1]     = 1'b1;
                tick_raise_d = 1'b1;
              end
            end
          end
        end else if (head_valid_i && out_free) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          out_rd_d    = '0;
          out_raise_d = 1'b0;
          out_clr_d   = 1'b0;
          out_fetch_d = 1'b0;
          out_addr_d  = '0;
          out_stall_d = '0;
          case (head_cmd_i.op)
            OP_WR_RATE: begin
              smp_period_d = rate_period(head_cmd_i.data[3:0]);
              if (irq_q[1] && !head_cmd_i.data[7]) begin
                irq_d[1]  = 1'b0;
                out_clr_d = 1'b1;
              end
              fmt_d = head_cmd_i.data;
            end
            OP_WR_ADDR: addr_latch_d = head_cmd_i.data;
            OP_WR_LEN:  len_latch_d  = head_cmd_i.data;
            OP_WR_CTRL: begin
              if (head_cmd_i.data[4]) begin
                if (bytes_q == '0) begin
                  smp_addr_d = load_addr;
                  bytes_d    = load_len;
                end
              end else begin
                bytes_d = '0;
              end
              irq_d[1]  = 1'b0;
              out_clr_d = 1'b1;
            end
            OP_WR_FRAME: begin
              frame_step_d = 2'd1;
              frame_acc_d  = {2'b0, frame_period_q};
              irq_d[0]     = 1'b0;
              out_clr_d    = 1'b1;
              frame_mode_d = head_cmd_i.data[7:6];
            end
            OP_READ: begin
              out_rd_d  = {irq_q[1], irq_q[0], 1'b0, (bytes_q != '0), 4'b0};
              irq_d[0]  = 1'b0;
              out_clr_d = 1'b1;
            end
            OP_SRESET: begin
              frame_mode_d = '0;
              frame_acc_d  = {2'b0, frame_period_q};
              frame_step_d = '0;
              irq_d        = '0;
              fetch_done_d = 1'b0;
              addr_latch_d = '0;
              len_latch_d  = '0;
              fmt_d        = '0;
              smp_addr_d   = '0;
              bytes_d      = '0;
              smp_acc_d    = 10'sd1;
              bit_cnt_d    = '0;
            end
            default: ;
          endcase
        end
      end
      BK_TICK2: begin
        if (out_free) begin
          state_d     = BK_RUN;
          out_valid_d = 1'b1;
          out_rd_d    = '0;
          out_clr_d   = 1'b0;
          out_raise_d = tick_raise_q;
          out_fetch_d = tick_fetch_q;
          out_addr_d  = tick_addr_q;
          out_stall_d = tick_fetch_q ? FETCH_STALL : 3'd0;
          if (frame_le0) begin
            if (frame_step_q == 2'd0 && frame_mode_q == 2'd0) begin
              irq_d[0]    = 1'b1;
              out_raise_d = 1'b1;
            end
            frame_step_d = frame_step_q + 2'd1;
            frame_acc_d  = frame_acc_q + reload_amt;
          end
          smp_acc_d = s2;
          bit_cnt_d = bc2;
          if ((n1 && bc1 == 3'd0) || (n2 && bc2 == 3'd0)) begin
            fetch_done_d = 1'b0;
          end
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_RUN;
      frame_period_q <= FRAME_PERIOD_RESET;
      frame_acc_q    <= {2'b0, FRAME_PERIOD_RESET};
      frame_step_q   <= '0;
      frame_mode_q   <= '0;
      irq_q          <= '0;
      smp_acc_q      <= 10'sd1;
      smp_period_q   <= SMP_PERIOD_RESET;
      smp_addr_q     <= '0;
      bytes_q        <= '0;
      fmt_q          <= '0;
      addr_latch_q   <= '0;
      len_latch_q    <= '0;
      bit_cnt_q      <= '0;
      fetch_done_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      frame_period_q <= frame_period_d;
      frame_acc_q    <= frame_acc_d;
      frame_step_q   <= frame_step_d;
      frame_mode_q   <= frame_mode_d;
      irq_q          <= irq_d;
      smp_acc_q      <= smp_acc_d;
      smp_period_q   <= smp_period_d;
      smp_addr_q     <= smp_addr_d;
      bytes_q        <= bytes_d;
      fmt_q          <= fmt_d;
      addr_latch_q   <= addr_latch_d;
      len_latch_q    <= len_latch_d;
      bit_cnt_q      <= bit_cnt_d;
      fetch_done_q   <= fetch_done_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_cycles_q <= tick_cycles_d;
    tick_raise_q  <= tick_raise_d;
    tick_fetch_q  <= tick_fetch_d;
    tick_addr_q   <= tick_addr_d;
    out_rd_q      <= out_rd_d;
    out_raise_q   <= out_raise_d;
    out_clr_q     <= out_clr_d;
    out_fetch_q   <= out_fetch_d;
    out_addr_q    <= out_addr_d;
    out_stall_q   <= out_stall_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rd_q;
  assign irq_raise_o    = out_raise_q;
  assign irq_clear_o    = out_clr_q;
  assign dma_fetch_o    = out_fetch_q;
  assign dma_address_o  = out_addr_q;
  assign stall_cycles_o = out_stall_q;

  `ADFIT_ASSERT_IMP(a_smp_acc_pos, state_q == BK_RUN, smp_acc_q > 10'sd0)
  `ADFIT_ASSERT_IMP(a_fetch_marks_done, state_q == BK_TICK2 && tick_fetch_q, fetch_done_q)
  `ADFIT_ASSERT_NEXT(a_tick2_holds, state_q == BK_TICK2 && !out_free, state_q == BK_TICK2)
  `ADFIT_ASSERT_IMP(a_fetch_addr_rom, out_valid_q && out_fetch_q, out_addr_q[15])

endmodule

>>> rtl/apu_dmc_frame_irq_timing_top.sv
// Top level of the DMC and frame counter timing block.
// Instantiates adfit_front, adfit_queue and adfit_back; uses adfit_pkg.
// Path: an item enters the queue, then the output register; a tick also passes BK_TICK2.
// Throughput: a tick makes two passes through back-end accumulators, blocking the next
// item; any other item one per cycle while out_stall_i is low. A two-entry queue decouples
// input from back end. Reset: rst_ni clears control state; no clearing pass needed.
module apu_dmc_frame_irq_timing_top import adfit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  cycles_i,
  input  logic [2:0]  reg_index_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        irq_raise_o,
  output logic        irq_clear_o,
  output logic        dma_fetch_o,
  output logic [15:0] dma_address_o,
  output logic [2:0]  stall_cycles_o
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign cfg_ready_o = 1'b1;

  adfit_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .cycles_i     (cycles_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  adfit_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  adfit_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .head_valid_i   (head_valid),
    .head_cmd_i     (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .irq_raise_o    (irq_raise_o),
    .irq_clear_o    (irq_clear_o),
    .dma_fetch_o    (dma_fetch_o),
    .dma_address_o  (dma_address_o),
    .stall_cycles_o (stall_cycles_o)
  );

endmodule
